// File: hw/rtl/ptfp_pkg.sv
// Package for the PSU telemetry frame parser.
// Holds frame constants, quantity codes and byte offsets; no dependencies.
package ptfp_pkg;

  localparam int unsigned PayloadKeep = 32;
  localparam int unsigned PayIdxW     = $clog2(PayloadKeep);

  localparam logic [7:0] HdrFirst   = 8'h55;
  localparam logic [7:0] HdrSecond  = 8'h7E;
  localparam logic [7:0] TypeElec   = 8'h02;
  localparam logic [7:0] TypeStat   = 8'h04;
  localparam logic [7:0] MinElecLen = 8'd27;
  localparam logic [7:0] MinStatLen = 8'd28;

  localparam int unsigned QtyW   = 5;
  localparam int unsigned ValueW = 28;
  localparam int unsigned TotalW = 25;

  localparam logic [QtyW-1:0] QtyPower3v3  = 5'd10;
  localparam logic [QtyW-1:0] QtyPower5v   = 5'd11;
  localparam logic [QtyW-1:0] QtyPower12v  = 5'd12;
  localparam logic [QtyW-1:0] QtyPowerTot  = 5'd13;
  localparam logic [QtyW-1:0] QtyFanMode   = 5'd14;
  localparam logic [QtyW-1:0] QtyEff       = 5'd19;

  // Low-byte offset of each little-endian raw word, quantity codes 0..9.
  function automatic logic [PayIdxW-1:0] elec_offset(input logic [3:0] k);
    case (k)
      4'd0: elec_offset = PayIdxW'(1);
      4'd1: elec_offset = PayIdxW'(3);
      4'd2: elec_offset = PayIdxW'(5);
      4'd3: elec_offset = PayIdxW'(7);
      4'd4: elec_offset = PayIdxW'(9);
      4'd5: elec_offset = PayIdxW'(11);
      4'd6: elec_offset = PayIdxW'(13);
      4'd7: elec_offset = PayIdxW'(15);
      4'd8: elec_offset = PayIdxW'(23);
      default: elec_offset = PayIdxW'(25);
    endcase
  endfunction

  // High-byte offset of big-endian status words, quantity codes 15..18.
  function automatic logic [PayIdxW-1:0] stat_offset(input logic [1:0] k);
    case (k)
      2'd0: stat_offset = PayIdxW'(2);
      2'd1: stat_offset = PayIdxW'(12);
      2'd2: stat_offset = PayIdxW'(24);
      default: stat_offset = PayIdxW'(14);
    endcase
  endfunction

endpackage

// File: hw/rtl/ptfp_divider.sv
// Restoring divider, one quotient bit per cycle, 28-bit quotient.
// Depends on ptfp_pkg.
module ptfp_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [34:0]                   num_i,
  input  logic [23:0]                   den_i,
  output logic                          done_o,
  output logic [ptfp_pkg::ValueW-1:0]   quot_o
);
  // num < 2^35, den >= 100, so quotient < 2^29; keep low 28 bits.
  logic [34:0] num_q, num_d;
  logic [23:0] den_q, den_d;
  logic [24:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [24:0] trial;
  logic [25:0] diff;

  assign trial = {rem_q[23:0], num_q[34]};
  assign diff  = {1'b0, trial} - {2'b0, den_q};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = 6'd35;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[25]) begin
        rem_d = diff[24:0];
      end else begin
        rem_d = trial;
      end
      num_d = {num_q[33:0], ~diff[25]};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quot_o = {num_q[26:0], ~diff[25]};

  done_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_q) else $error("divider done while idle");
  start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  finish_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("divider did not stop");
endmodule

// File: hw/rtl/psu_telemetry_frame_parser.sv
// PSU telemetry frame parser, top level.
// Depends on ptfp_pkg and ptfp_divider.
//
// Usage:
//   Bytes of a serial stream enter on rx_byte_i with rx_valid_i/rx_ready_o.
//   Results leave on quantity_o, value_o and last_of_frame_o with
//   out_valid_o/out_ready_i; each accepted result is one request.
//   The parser hunts for 0x55 0x7E, takes a length byte, then stores the
//   first 32 payload bytes in a register file. At the end of a type-2
//   frame (length >= 27) it emits 14 requests; at the end of a type-4
//   frame (length >= 28) it emits 6. Other frames emit nothing.
//   A byte that does not end a decoded frame is taken without a stall.
//   A frame end runs a sequencer over one shared 16x16 multiplier, one shared
//   adder and one divider: an electrical frame emits each raw word, then
//   multiplies and emits each rail power, then emits the total; a status
//   frame emits its first five requests, tests the operands, runs the
//   bit-serial divider when both are nonzero, and emits the efficiency request.
//   The output register holds one request; the sequencer stalls while it is
//   full and out_ready_i is low, and no byte is taken until the last request
//   of the frame is loaded. Reset (rst_ni low, asynchronous) returns to the
//   hunt and clears total power and efficiency; payload bytes are not cleared.
module psu_telemetry_frame_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rx_valid_i,
  output logic                                rx_ready_o,
  input  logic [7:0]                          rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ptfp_pkg::QtyW-1:0]           quantity_o,
  output logic [ptfp_pkg::ValueW-1:0]         value_o,
  output logic                                last_of_frame_o
);
  localparam int unsigned PW = ptfp_pkg::PayIdxW;

  typedef enum logic [3:0] {
    StHunt, StHdr2, StLen, StPay,
    StElecRaw, StElecMul, StElecPow, StElecTot,
    StStatRaw, StStatMul, StStatDiv, StStatEff
  } state_e;

  state_e state_q;
  logic [7:0] len_q, taken_q;
  logic [7:0] pay_q [ptfp_pkg::PayloadKeep];
  logic [ptfp_pkg::TotalW-1:0] total_q;
  logic [ptfp_pkg::ValueW-1:0] eff_q;
  logic [3:0] idx_q;
  logic [31:0] prod_q;
  logic [ptfp_pkg::TotalW-1:0] acc_q;

  logic                       ov_q;
  logic [ptfp_pkg::QtyW-1:0]  oq_q;
  logic [ptfp_pkg::ValueW-1:0] ovl_q;
  logic                       ol_q;

  logic out_free;
  assign out_free = !ov_q || out_ready_i;

  // Load the output register whenever an emitting state finds it free.
  logic load_out;
  assign load_out = out_free && (state_q inside {StElecRaw, StElecPow, StElecTot,
                                                 StStatRaw, StStatEff});

  logic rx_fire;
  assign rx_ready_o = (state_q == StHunt) || (state_q == StHdr2) ||
                      (state_q == StLen) || (state_q == StPay);
  assign rx_fire = rx_valid_i && rx_ready_o;

  // Shared byte reads: little-endian raw word and big-endian status word.
  logic [PW-1:0] lo_a, be_a;
  logic [15:0] word_le, word_be;
  assign lo_a    = ptfp_pkg::elec_offset(idx_q);
  assign word_le = {pay_q[lo_a + PW'(1)], pay_q[lo_a]};
  // Status words run at idx 1..4 and map onto offset slots 0..3.
  assign be_a    = ptfp_pkg::stat_offset(2'(idx_q - 4'd1));
  assign word_be = {pay_q[be_a], pay_q[be_a + PW'(1)]};

  // Shared multiplier: rail voltage times current (idx 0..2 -> words k, k+4).
  logic [PW-1:0] va, ca;
  assign va = ptfp_pkg::elec_offset(idx_q);
  assign ca = ptfp_pkg::elec_offset(idx_q + 4'd4);
  logic [31:0] mul;
  assign mul = {pay_q[va + PW'(1)], pay_q[va]} * {pay_q[ca + PW'(1)], pay_q[ca]};

  logic [ptfp_pkg::ValueW-1:0] pow;
  assign pow = (idx_q == 4'd2) ? ptfp_pkg::ValueW'(prod_q >> 8)
                               : ptfp_pkg::ValueW'(prod_q >> 12);

  // Efficiency: total*1000 / (ac*100), via shared divider.
  logic div_start, div_done;
  logic [ptfp_pkg::ValueW-1:0] div_q;
  logic [15:0] ac_q;
  ptfp_divider u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (35'(total_q) * 35'd1000),
    .den_i   (24'(ac_q) * 24'd100),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  always_comb div_start = (state_q == StStatDiv) && (idx_q == 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StHunt;
      len_q   <= '0;
      taken_q <= '0;
      total_q <= '0;
      eff_q   <= '0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      ov_q <= load_out || (ov_q && !out_ready_i);
      unique case (state_q)
        StHunt: if (rx_fire && rx_byte_i == ptfp_pkg::HdrFirst) state_q <= StHdr2;
        StHdr2: if (rx_fire) begin
          if (rx_byte_i == ptfp_pkg::HdrSecond) state_q <= StLen;
          else if (rx_byte_i != ptfp_pkg::HdrFirst) state_q <= StHunt;
        end
        StLen: if (rx_fire) begin
          len_q   <= rx_byte_i;
          taken_q <= '0;
          state_q <= (rx_byte_i == 8'd0) ? StHunt : StPay;
        end
        StPay: if (rx_fire) begin
          taken_q <= taken_q + 8'd1;
          idx_q   <= '0;
          if (taken_q + 8'd1 == len_q) begin
            state_q <= StHunt;
            // Type byte may be arriving now when length is one; that case
            // never decodes since the length minimums exceed one.
            if (pay_q[0] == ptfp_pkg::TypeElec && len_q >= ptfp_pkg::MinElecLen)
              state_q <= StElecRaw;
            else if (pay_q[0] == ptfp_pkg::TypeStat && len_q >= ptfp_pkg::MinStatLen)
              state_q <= StStatRaw;
          end
        end
        StElecRaw: if (out_free) begin
          oq_q  <= ptfp_pkg::QtyW'(idx_q);
          ovl_q <= ptfp_pkg::ValueW'(word_le);
          ol_q  <= 1'b0;
          if (idx_q == 4'd9) begin
            idx_q   <= '0;
            acc_q   <= '0;
            state_q <= StElecMul;
          end else idx_q <= idx_q + 4'd1;
        end
        StElecMul: begin
          prod_q  <= mul;
          state_q <= StElecPow;
        end
        StElecPow: if (out_free) begin
          oq_q  <= ptfp_pkg::QtyPower3v3 + ptfp_pkg::QtyW'(idx_q);
          ovl_q <= pow;
          ol_q  <= 1'b0;
          acc_q <= acc_q + ptfp_pkg::TotalW'(pow);
          if (idx_q == 4'd2) state_q <= StElecTot;
          else begin
            idx_q   <= idx_q + 4'd1;
            state_q <= StElecMul;
          end
        end
        StElecTot: if (out_free) begin
          oq_q    <= ptfp_pkg::QtyPowerTot;
          ovl_q   <= ptfp_pkg::ValueW'(acc_q);
          ol_q    <= 1'b1;
          total_q <= acc_q;
          state_q <= StHunt;
        end
        StStatRaw: if (out_free) begin
          ol_q <= 1'b0;
          if (idx_q == 4'd0) begin
            oq_q  <= ptfp_pkg::QtyFanMode;
            ovl_q <= ptfp_pkg::ValueW'(pay_q[1]);
            idx_q <= 4'd1;
          end else begin
            oq_q  <= ptfp_pkg::QtyFanMode + ptfp_pkg::QtyW'(idx_q);
            ovl_q <= ptfp_pkg::ValueW'(word_be);
            if (idx_q == 4'd4) begin
              ac_q    <= word_be;
              idx_q   <= '0;
              state_q <= StStatMul;
            end else idx_q <= idx_q + 4'd1;
          end
        end
        StStatMul: begin
          state_q <= (ac_q != 16'd0 && total_q != '0) ? StStatDiv : StStatEff;
        end
        StStatDiv: begin
          idx_q <= 4'd1;
          if (div_done) begin
            eff_q   <= div_q;
            state_q <= StStatEff;
          end
        end
        StStatEff: if (out_free) begin
          oq_q    <= ptfp_pkg::QtyEff;
          ovl_q   <= eff_q;
          ol_q    <= 1'b1;
          idx_q   <= '0;
          state_q <= StHunt;
        end
        default: state_q <= StHunt;
      endcase
    end
  end

  // Store payload; bytes beyond the keep depth are counted only.
  always_ff @(posedge clk_i) begin
    if (rx_fire && state_q == StPay && taken_q < 8'(ptfp_pkg::PayloadKeep))
      pay_q[taken_q[PW-1:0]] <= rx_byte_i;
  end

  assign out_valid_o     = ov_q;
  assign quantity_o      = oq_q;
  assign value_o         = ovl_q;
  assign last_of_frame_o = ol_q;

  no_rx_while_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StElecRaw || state_q == StStatDiv) |-> !rx_ready_o)
    else $error("byte taken during decode");
  last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ol_q) |-> (oq_q == ptfp_pkg::QtyPowerTot || oq_q == ptfp_pkg::QtyEff))
    else $error("bad last marker");
  hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable(oq_q) && $stable(ovl_q)))
    else $error("result overwritten while stalled");
endmodule

// File: sim/tb_top.sv
// Testbench for the PSU telemetry frame parser: streams framed serial bytes,
// predicts every decoded measurement and checks each result as it leaves.
// Depends on ptfp_pkg and psu_telemetry_frame_parser.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 4000;

  typedef struct packed {
    logic [ptfp_pkg::QtyW-1:0]   qty;
    logic [ptfp_pkg::ValueW-1:0] val;
    logic                        last;
  } meas_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic rx_valid_i = 1'b0;
  logic rx_ready_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ptfp_pkg::QtyW-1:0] quantity_o;
  logic [ptfp_pkg::ValueW-1:0] value_o;
  logic last_of_frame_o;

  always #10 clk_i = ~clk_i;

  psu_telemetry_frame_parser uut (
    .clk_i, .rst_ni, .rx_valid_i, .rx_ready_o, .rx_byte_i,
    .out_valid_o, .out_ready_i, .quantity_o, .value_o, .last_of_frame_o
  );

  // Predictor state: parser phase, frame progress, kept payload, sticky figures.
  logic [1:0] phase_q;
  logic [7:0] flen_q, taken_q;
  logic [7:0] pay_q [ptfp_pkg::PayloadKeep];
  logic [ptfp_pkg::TotalW-1:0] tot_pwr_q;
  logic [ptfp_pkg::ValueW-1:0] eff_q;

  meas_t expected_meas[$];
  int errors = 0;
  int bytes_sent = 0;
  int meas_seen = 0;
  int frames_elec = 0;
  int frames_stat = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  function automatic logic [15:0] le_word(int i);
    return {pay_q[i+1], pay_q[i]};
  endfunction

  function automatic logic [15:0] be_word(int i);
    return {pay_q[i], pay_q[i+1]};
  endfunction

  task automatic push_meas(logic [ptfp_pkg::QtyW-1:0] q, logic [ptfp_pkg::ValueW-1:0] v,
                           logic l);
    meas_t m;
    m.qty = q;
    m.val = v;
    m.last = l;
    expected_meas.push_back(m);
  endtask

  // Advance the frame predictor by one byte; queue the decoded measurements.
  task automatic predict_byte(logic [7:0] b);
    int offs[10] = '{1, 3, 5, 7, 9, 11, 13, 15, 23, 25};
    logic [15:0] w[10];
    logic [63:0] p3, p5, p12, num, den;
    logic [15:0] ac;
    case (phase_q)
      2'd0: if (b == ptfp_pkg::HdrFirst) phase_q = 2'd1;
      2'd1: begin
        if (b == ptfp_pkg::HdrSecond) phase_q = 2'd2;
        else if (b != ptfp_pkg::HdrFirst) phase_q = 2'd0;
      end
      2'd2: begin
        flen_q = b;
        taken_q = 8'd0;
        phase_q = (b == 8'd0) ? 2'd0 : 2'd3;
      end
      default: begin
        if (taken_q < ptfp_pkg::PayloadKeep) pay_q[taken_q] = b;
        taken_q = taken_q + 8'd1;
        if (taken_q == flen_q) begin
          phase_q = 2'd0;
          if (pay_q[0] == ptfp_pkg::TypeElec && flen_q >= ptfp_pkg::MinElecLen) begin
            frames_elec++;
            for (int k = 0; k < 10; k++) begin
              w[k] = le_word(offs[k]);
              push_meas(ptfp_pkg::QtyW'(k), ptfp_pkg::ValueW'(w[k]), 1'b0);
            end
            p3 = (64'(w[0]) * 64'(w[4])) >> 12;
            p5 = (64'(w[1]) * 64'(w[5])) >> 12;
            p12 = (64'(w[2]) * 64'(w[6])) >> 8;
            tot_pwr_q = ptfp_pkg::TotalW'(p3 + p5 + p12);
            push_meas(ptfp_pkg::QtyPower3v3, ptfp_pkg::ValueW'(p3), 1'b0);
            push_meas(ptfp_pkg::QtyPower5v, ptfp_pkg::ValueW'(p5), 1'b0);
            push_meas(ptfp_pkg::QtyPower12v, ptfp_pkg::ValueW'(p12), 1'b0);
            push_meas(ptfp_pkg::QtyPowerTot, ptfp_pkg::ValueW'(tot_pwr_q), 1'b1);
          end else if (pay_q[0] == ptfp_pkg::TypeStat &&
                       flen_q >= ptfp_pkg::MinStatLen) begin
            frames_stat++;
            ac = be_word(14);
            push_meas(ptfp_pkg::QtyFanMode, ptfp_pkg::ValueW'(pay_q[1]), 1'b0);
            push_meas(ptfp_pkg::QtyFanMode + 5'd1, ptfp_pkg::ValueW'(be_word(2)), 1'b0);
            push_meas(ptfp_pkg::QtyFanMode + 5'd2, ptfp_pkg::ValueW'(be_word(12)), 1'b0);
            push_meas(ptfp_pkg::QtyFanMode + 5'd3, ptfp_pkg::ValueW'(be_word(24)), 1'b0);
            push_meas(ptfp_pkg::QtyFanMode + 5'd4, ptfp_pkg::ValueW'(ac), 1'b0);
            // Keep the old efficiency when either operand is zero.
            if (ac != 16'd0 && tot_pwr_q != '0) begin
              num = 64'(tot_pwr_q) * 64'd1000;
              den = 64'(ac) * 64'd100;
              eff_q = ptfp_pkg::ValueW'(num / den);
            end
            push_meas(ptfp_pkg::QtyEff, eff_q, 1'b1);
          end
        end
      end
    endcase
  endtask

  // Send one byte; hold valid and payload until accepted.
  task automatic send_byte(logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(logic [7:0] pay[$]);
    send_byte(ptfp_pkg::HdrFirst);
    send_byte(ptfp_pkg::HdrSecond);
    send_byte(8'(pay.size()));
    foreach (pay[i]) send_byte(pay[i]);
  endtask

  function automatic void fill_payload(ref logic [7:0] pay[$], input logic [7:0] kind,
                                       input int len, input bit extreme_hi);
    pay.delete();
    pay.push_back(kind);
    for (int i = 1; i < len; i++)
      pay.push_back(extreme_hi ? 8'hFF : 8'($urandom_range(255)));
  endfunction

  // Drop valid, let the block drain, plus a margin for a final division.
  task automatic drain();
    int guard = 0;
    rx_valid_i <= 1'b0;
    while (expected_meas.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  task automatic test_decode_figures();
    logic [7:0] pay[$];
    // Extreme words: all ones, then a status frame that computes an efficiency.
    fill_payload(pay, ptfp_pkg::TypeElec, 27, 1'b1);
    send_frame(pay);
    fill_payload(pay, ptfp_pkg::TypeStat, 28, 1'b1);
    send_frame(pay);
    // Zero AC power with a live total: efficiency is kept.
    fill_payload(pay, ptfp_pkg::TypeStat, 28, 1'b0);
    pay[14] = 8'h00;
    pay[15] = 8'h00;
    send_frame(pay);
    // All-zero words give a zero total; the next status keeps the efficiency.
    pay.delete();
    pay.push_back(ptfp_pkg::TypeElec);
    for (int i = 1; i < 27; i++) pay.push_back(8'h00);
    send_frame(pay);
    fill_payload(pay, ptfp_pkg::TypeStat, 28, 1'b0);
    send_frame(pay);
    drain();
  endtask

  task automatic test_odd_frames();
    logic [7:0] pay[$];
    // Repeated first header byte, a broken header and a zero length frame.
    send_byte(ptfp_pkg::HdrFirst);
    send_byte(ptfp_pkg::HdrFirst);
    send_byte(ptfp_pkg::HdrSecond);
    send_byte(8'd0);
    send_byte(ptfp_pkg::HdrFirst);
    send_byte(8'h12);
    // Electrical frame one byte short of the minimum.
    fill_payload(pay, ptfp_pkg::TypeElec, 26, 1'b0);
    send_frame(pay);
    // Long frame with headers inside: bytes past the store are dropped.
    fill_payload(pay, ptfp_pkg::TypeElec, 36, 1'b0);
    pay[33] = ptfp_pkg::HdrFirst;
    pay[34] = ptfp_pkg::HdrSecond;
    send_frame(pay);
    drain();
  endtask

  task automatic test_random_traffic(int budget);
    logic [7:0] pay[$];
    int pick, len;
    while (bytes_sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // Line noise.
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
      end else if (pick < 18) begin
        // Broken or odd frames.
        len = $urandom_range(0, 40);
        fill_payload(pay, 8'($urandom_range(255)), (len == 0) ? 1 : len, 1'b0);
        if (len == 0) begin
          send_byte(ptfp_pkg::HdrFirst);
          send_byte(ptfp_pkg::HdrSecond);
          send_byte(8'd0);
        end else send_frame(pay);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(33, 60) : $urandom_range(28, 31);
        fill_payload(pay, (pick < 60) ? ptfp_pkg::TypeElec : ptfp_pkg::TypeStat, len, 1'b0);
        if ($urandom_range(5) == 0) begin
          pay[14] = 8'h00;
          pay[15] = 8'h00;
        end
        send_frame(pay);
      end
    end
    drain();
  endtask

  // Check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    meas_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      meas_seen++;
      if (expected_meas.size() == 0) begin
        $error("unexpected result quantity=%0d value=%0d", quantity_o, value_o);
        errors++;
      end else begin
        e = expected_meas.pop_front();
        if (quantity_o !== e.qty) begin
          $error("quantity expected %0d actual %0d", e.qty, quantity_o);
          errors++;
        end
        if (value_o !== e.val) begin
          $error("value expected %0d actual %0d", e.val, value_o);
          errors++;
        end
        if (last_of_frame_o !== e.last) begin
          $error("last_of_frame expected %0d actual %0d", e.last, last_of_frame_o);
          errors++;
        end
      end
    end
  end

  // Randomly stall the result side.
  always @(posedge clk_i) begin
    out_ready_i <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no request moved for %0d cycles", QuietLimit);
      $display("FAIL psu_telemetry_frame_parser");
      $finish;
    end
  end

  initial begin
    phase_q = 2'd0;
    flen_q = 8'd0;
    taken_q = 8'd0;
    tot_pwr_q = '0;
    eff_q = '0;
    foreach (pay_q[i]) pay_q[i] = 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 38;
    recv_idle_pct = 46;
    test_decode_figures();
    send_idle_pct = 46;
    recv_idle_pct = 38;
    test_odd_frames();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(bytes_sent + 20);
    $display("Covered %0d bytes, %0d electrical and %0d status frames, %0d results.",
             bytes_sent, frames_elec, frames_stat, meas_seen);
    if (errors == 0 && expected_meas.size() == 0) begin
      $display("PASS psu_telemetry_frame_parser");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, expected_meas.size());
      $display("FAIL psu_telemetry_frame_parser");
    end
    $finish;
  end

endmodule
